// ===== rtl/sbse_pkg.sv =====
`default_nettype none

package sbse_pkg;

  localparam int XW = 32;
  localparam int LW = 31;

  typedef enum logic [1:0] {
    CFG_DOMAIN_X = 2'd0,
    CFG_DOMAIN_Y = 2'd1,
    CFG_SHEAR    = 2'd2
  } cfg_idx_t;

  localparam logic [LW-1:0] LEN_MAX      = '1;
  localparam logic [LW-1:0] DOMAIN_RESET = 31'd65536;
  localparam logic [XW-1:0] STRAIN_MAX   = 32'h7FFF_FFFF;
  localparam logic [XW-1:0] STRAIN_MIN   = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== rtl/sheared_bond_strain_energy.sv =====
// Bond separation, length, strain and energy under sheared periodic boundaries.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects box
//   width, box height or shear strain, cfg_data holds the value. cfg_ready is
//   always high. Write only while no bond is in flight.
// Input: one bond per transfer on in_valid/in_ready (end positions, rest
//   length, stiffness). Output: one result per bond on out_valid/out_ready,
//   in order.
// Pipeline: bit-per-stage units (y fold divider, shear index divider,
//   64-bit x fold divider, 32-stage square root and strain divider), plus
//   22 arithmetic stages.
// Throughput: one bond per cycle while out_ready is high.
// Stall: the whole pipeline holds while a result waits and out_ready is low;
//   in_ready is low in that case and nothing is lost or repeated.
// Reset: clears all valid bits and loads box 65536 x 65536 (1.0 x 1.0 at FRAC_BITS = 16) and zero shear.
`default_nettype none

module sheared_bond_strain_energy #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] src_x,
  input  logic signed [31:0] src_y,
  input  logic signed [31:0] dst_x,
  input  logic signed [31:0] dst_y,
  input  logic [30:0]        natural_length,
  input  logic [30:0]        stiffness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sep_x,
  output logic signed [31:0] sep_y,
  output logic [30:0]        bond_length,
  output logic signed [31:0] rel_strain,
  output logic [30:0]        energy
);

  localparam int F    = FRAC_BITS;
  localparam int LW   = sbse_pkg::LW;
  localparam int XW   = sbse_pkg::XW;
  localparam int SXW  = 64 - F;
  localparam int KW   = 34;
  localparam int WW   = 64;
  localparam int DNW  = LW + F;
  localparam int S2W  = 63 - F;
  localparam int H    = S2W / 2;
  localparam int PRW  = LW + S2W;
  localparam int SQN  = 32;
  localparam int RMW  = 34;
  localparam logic [63:0] RND = 64'd1 << (F - 1);

  logic [LW-1:0] domain_x;
  logic [LW-1:0] domain_y;
  logic [XW-1:0] shear_strain;
  logic          adv;

  assign cfg_ready = 1'b1;
  assign adv       = ~out_valid | out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_x     <= sbse_pkg::DOMAIN_RESET;
      domain_y     <= sbse_pkg::DOMAIN_RESET;
      shear_strain <= '0;
    end else if (cfg_valid) begin
      case (sbse_pkg::cfg_idx_t'(cfg_index))
        sbse_pkg::CFG_DOMAIN_X: domain_x     <= cfg_data[LW-1:0];
        sbse_pkg::CFG_DOMAIN_Y: domain_y     <= cfg_data[LW-1:0];
        sbse_pkg::CFG_SHEAR:    shear_strain <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage registers
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14;
  logic v15, v16, v17, v18, v19, v20, v21;

  logic [32:0]    s1_dx, s1_dy;
  logic [LW-1:0]  s1_n, s1_mu;
  logic [63:0]    s1_p;

  logic [SXW-1:0] s2_sx;
  logic [32:0]    s2_ady, s2_dx, s2_dy;
  logic           s2_dyneg;
  logic [LW-1:0]  s2_n, s2_mu;

  logic [SXW-1:0] s3_asx;
  logic           s3_sxneg, s3_dyneg;
  logic [32:0]    s3_ady, s3_dx, s3_dy;
  logic [LW-1:0]  s3_n, s3_mu;

  logic [LW-1:0]  s4_ryf, s4_smf, s4_n, s4_mu;
  logic [KW-1:0]  s4_qyf;
  logic [32:0]    s4_dx, s4_dy;

  logic [31:0]    s5_fy;
  logic [KW-1:0]  s5_k;
  logic [LW-1:0]  s5_smf, s5_n, s5_mu;
  logic [32:0]    s5_dx, s5_dy;

  logic [KW-1:0]  s6_ak;
  logic           s6_kneg;
  logic [31:0]    s6_fy;
  logic [LW-1:0]  s6_smf, s6_n, s6_mu;
  logic [32:0]    s6_dx, s6_dy;

  logic [LW-1:0]  s7_kmf, s7_smf, s7_n, s7_mu;
  logic [31:0]    s7_fy;
  logic [32:0]    s7_dx, s7_dy;

  logic [61:0]    s8_prod;
  logic [LW-1:0]  s8_n, s8_mu;
  logic [31:0]    s8_fy;
  logic [32:0]    s8_dx, s8_dy;

  logic [WW-1:0]  s9_w;
  logic [LW-1:0]  s9_n, s9_mu;
  logic [31:0]    s9_fy;
  logic [32:0]    s9_dx, s9_dy;

  logic [WW-1:0]  s10_aw;
  logic           s10_wneg;
  logic [LW-1:0]  s10_n, s10_mu;
  logic [31:0]    s10_fy;
  logic [32:0]    s10_dx, s10_dy;

  logic [LW-1:0]  s11_rwf, s11_n, s11_mu;
  logic [31:0]    s11_fy;
  logic [32:0]    s11_dx, s11_dy;

  logic [31:0]    s12_sepx, s12_sepy;
  logic [LW-1:0]  s12_n, s12_mu;

  logic [63:0]    s13_sqx, s13_sqy;
  logic [31:0]    s13_sepx, s13_sepy;
  logic [LW-1:0]  s13_n, s13_mu;

  logic [63:0]    s14_sq;
  logic [31:0]    s14_sepx, s14_sepy;
  logic [LW-1:0]  s14_n, s14_mu;

  logic [LW-1:0]  s15_len, s15_n, s15_mu;
  logic [31:0]    s15_sepx, s15_sepy;

  logic [31:0]    s16_diff;
  logic           s16_nz;
  logic [LW-1:0]  s16_len, s16_n, s16_mu;
  logic [31:0]    s16_sepx, s16_sepy;

  logic [LW-1:0]  s17_ad, s17_len, s17_n, s17_mu;
  logic           s17_dneg, s17_nz;
  logic [31:0]    s17_sepx, s17_sepy;

  logic [31:0]    s18_strain;
  logic [LW-1:0]  s18_len, s18_mu;
  logic [31:0]    s18_sepx, s18_sepy;

  logic [S2W-1:0] s19_s2;
  logic [31:0]    s19_strain;
  logic [LW-1:0]  s19_len, s19_mu;
  logic [31:0]    s19_sepx, s19_sepy;

  logic [LW+H-1:0]     s20_plo;
  logic [S2W-H-1:0]    s20_s2hi;
  logic [31:0]         s20_strain;
  logic [LW-1:0]       s20_len, s20_mu;
  logic [31:0]         s20_sepx, s20_sepy;

  logic [LW+H-1:0]     s21_plo;
  logic [PRW-H-1:0]    s21_phi;
  logic [31:0]         s21_strain;
  logic [LW-1:0]       s21_len;
  logic [31:0]         s21_sepx, s21_sepy;

  // y fold and shear offset dividers
  localparam int SAW = 1 + 33 + 33 + LW + LW;
  logic           a_vld, s_vld;
  logic [SXW-1:0] a_q;
  logic [LW-1:0]  a_r, s_r;
  logic [SAW-1:0] a_side;
  logic           s_side;
  logic           a_dyneg;
  logic [32:0]    a_dy, a_dx;
  logic [LW-1:0]  a_n, a_mu;

  sbse_div #(.NW(SXW), .DW(LW), .SW(SAW)) u_div_y (
    .clk(clk), .rst(rst), .en(adv), .in_vld(v3),
    .num({{(SXW-33){1'b0}}, s3_ady}), .den(domain_y),
    .side_in({s3_dyneg, s3_dy, s3_dx, s3_n, s3_mu}),
    .out_vld(a_vld), .quo(a_q), .rem(a_r), .side_out(a_side)
  );

  sbse_div #(.NW(SXW), .DW(LW), .SW(1)) u_div_sx (
    .clk(clk), .rst(rst), .en(adv), .in_vld(v3),
    .num(s3_asx), .den(domain_x), .side_in(s3_sxneg),
    .out_vld(s_vld), .quo(), .rem(s_r), .side_out(s_side)
  );

  assign {a_dyneg, a_dy, a_dx, a_n, a_mu} = a_side;

  // shear index divider
  localparam int SBW = 1 + 32 + LW + 33 + 33 + LW + LW;
  logic          b_vld;
  logic [LW-1:0] b_r;
  logic [SBW-1:0] b_side;
  logic          b_kneg;
  logic [31:0]   b_fy;
  logic [LW-1:0] b_smf, b_n, b_mu;
  logic [32:0]   b_dx, b_dy;

  sbse_div #(.NW(KW), .DW(LW), .SW(SBW)) u_div_k (
    .clk(clk), .rst(rst), .en(adv), .in_vld(v6),
    .num(s6_ak), .den(domain_x),
    .side_in({s6_kneg, s6_fy, s6_smf, s6_dx, s6_dy, s6_n, s6_mu}),
    .out_vld(b_vld), .quo(), .rem(b_r), .side_out(b_side)
  );

  assign {b_kneg, b_fy, b_smf, b_dx, b_dy, b_n, b_mu} = b_side;

  // x fold divider
  localparam int SCW = 1 + 32 + 33 + 33 + LW + LW;
  logic          c_vld;
  logic [LW-1:0] c_r;
  logic [SCW-1:0] c_side;
  logic          c_wneg;
  logic [31:0]   c_fy;
  logic [32:0]   c_dx, c_dy;
  logic [LW-1:0] c_n, c_mu;

  sbse_div #(.NW(WW), .DW(LW), .SW(SCW)) u_div_x (
    .clk(clk), .rst(rst), .en(adv), .in_vld(v10),
    .num(s10_aw), .den(domain_x),
    .side_in({s10_wneg, s10_fy, s10_dx, s10_dy, s10_n, s10_mu}),
    .out_vld(c_vld), .quo(), .rem(c_r), .side_out(c_side)
  );

  assign {c_wneg, c_fy, c_dx, c_dy, c_n, c_mu} = c_side;

  // square root, one result bit per stage
  localparam int SQS = 32 + 32 + LW + LW;
  logic           q_vld  [1:SQN];
  logic [63:0]    q_rad  [1:SQN];
  logic [31:0]    q_rt   [1:SQN];
  logic [RMW-1:0] q_rm   [1:SQN];
  logic [SQS-1:0] q_sd   [1:SQN];

  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    logic           c_v;
    logic [63:0]    c_rad;
    logic [31:0]    c_rt;
    logic [RMW-1:0] c_rm;
    logic [SQS-1:0] c_sd;
    logic [RMW+1:0] cand;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign c_v   = v14;
      assign c_rad = s14_sq;
      assign c_rt  = '0;
      assign c_rm  = '0;
      assign c_sd  = {s14_sepx, s14_sepy, s14_n, s14_mu};
    end else begin : g_rest
      assign c_v   = q_vld[i];
      assign c_rad = q_rad[i];
      assign c_rt  = q_rt[i];
      assign c_rm  = q_rm[i];
      assign c_sd  = q_sd[i];
    end

    assign cand  = {c_rm, c_rad[63:62]};
    assign trial = {2'b00, c_rt, 2'b01};
    assign diff  = cand - trial;
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        q_vld[i+1] <= 1'b0;
      end else if (adv) begin
        q_vld[i+1] <= c_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_rad[i+1] <= {c_rad[61:0], 2'b00};
        q_rt[i+1]  <= {c_rt[30:0], ge};
        q_rm[i+1]  <= ge ? diff[RMW-1:0] : cand[RMW-1:0];
        q_sd[i+1]  <= c_sd;
      end
    end
  end

  logic [31:0]   q_sepx, q_sepy;
  logic [LW-1:0] q_n, q_mu;
  assign {q_sepx, q_sepy, q_n, q_mu} = q_sd[SQN];

  // strain divider
  localparam int SDW = 1 + 1 + LW + 32 + 32 + LW;
  logic           d_vld;
  logic [DNW-1:0] d_q;
  logic [SDW-1:0] d_side;
  logic           d_dneg, d_nz;
  logic [LW-1:0]  d_len, d_mu;
  logic [31:0]    d_sepx, d_sepy;

  sbse_div #(.NW(DNW), .DW(LW), .SW(SDW)) u_div_s (
    .clk(clk), .rst(rst), .en(adv), .in_vld(v17),
    .num({s17_ad, {F{1'b0}}}), .den(s17_n),
    .side_in({s17_dneg, s17_nz, s17_len, s17_sepx, s17_sepy, s17_mu}),
    .out_vld(d_vld), .quo(d_q), .rem(), .side_out(d_side)
  );

  assign {d_dneg, d_nz, d_len, d_sepx, d_sepy, d_mu} = d_side;

  // combinational helpers
  logic [63:0]   p_rnd;
  logic [KW-1:0] qy_up;
  logic          fy_up, fx_up, big_q;
  logic [31:0]   ryf_ext, rwf_ext, dabs;
  logic [63:0]   ssq;
  logic [PRW-1:0] eprod;

  assign p_rnd   = s1_p + RND;
  assign qy_up   = {1'b0, a_q[32:0]} + KW'(a_r != '0);
  assign ryf_ext = {1'b0, s4_ryf};
  assign fy_up   = {s4_ryf, 1'b0} > {1'b0, domain_y};
  assign rwf_ext = {1'b0, s11_rwf};
  assign fx_up   = {s11_rwf, 1'b0} > {1'b0, domain_x};
  assign dabs    = s16_diff[31] ? -s16_diff : s16_diff;
  assign big_q   = |d_q[DNW-1:31];
  assign ssq     = $signed(s18_strain) * $signed(s18_strain);
  assign eprod   = {s21_phi, {H{1'b0}}} + {{(PRW-LW-H){1'b0}}, s21_plo};

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <= '0;
      {v12, v13, v14, v15, v16, v17, v18, v19, v20, v21} <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= a_vld;
      v5  <= v4;
      v6  <= v5;
      v7  <= b_vld;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= c_vld;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
      v15 <= q_vld[SQN];
      v16 <= v15;
      v17 <= v16;
      v18 <= d_vld;
      v19 <= v18;
      v20 <= v19;
      v21 <= v20;
      out_valid <= v21;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // differences and shear product
      s1_dx <= {dst_x[31], dst_x} - {src_x[31], src_x};
      s1_dy <= {dst_y[31], dst_y} - {src_y[31], src_y};
      s1_n  <= natural_length;
      s1_mu <= stiffness;
      s1_p  <= $signed({1'b0, domain_x}) * $signed(shear_strain);

      s2_sx    <= p_rnd[63:F];
      s2_dyneg <= s1_dy[32];
      s2_ady   <= s1_dy[32] ? -s1_dy : s1_dy;
      s2_dx    <= s1_dx;
      s2_dy    <= s1_dy;
      s2_n     <= s1_n;
      s2_mu    <= s1_mu;

      s3_asx   <= s2_sx[SXW-1] ? -s2_sx : s2_sx;
      s3_sxneg <= s2_sx[SXW-1];
      s3_ady   <= s2_ady;
      s3_dyneg <= s2_dyneg;
      s3_dx    <= s2_dx;
      s3_dy    <= s2_dy;
      s3_n     <= s2_n;
      s3_mu    <= s2_mu;

      // floor remainders and quotient
      s4_ryf <= (a_dyneg && a_r != '0) ? domain_y - a_r : a_r;
      s4_qyf <= a_dyneg ? -qy_up : {1'b0, a_q[32:0]};
      s4_smf <= (s_side && s_r != '0) ? domain_x - s_r : s_r;
      s4_dx  <= a_dx;
      s4_dy  <= a_dy;
      s4_n   <= a_n;
      s4_mu  <= a_mu;

      s5_fy  <= fy_up ? ryf_ext - {1'b0, domain_y} : ryf_ext;
      s5_k   <= (domain_y == '0) ? '0 : s4_qyf + KW'(fy_up);
      s5_smf <= s4_smf;
      s5_dx  <= s4_dx;
      s5_dy  <= s4_dy;
      s5_n   <= s4_n;
      s5_mu  <= s4_mu;

      s6_ak   <= s5_k[KW-1] ? -s5_k : s5_k;
      s6_kneg <= s5_k[KW-1];
      s6_fy   <= s5_fy;
      s6_smf  <= s5_smf;
      s6_dx   <= s5_dx;
      s6_dy   <= s5_dy;
      s6_n    <= s5_n;
      s6_mu   <= s5_mu;

      s7_kmf <= (b_kneg && b_r != '0) ? domain_x - b_r : b_r;
      s7_smf <= b_smf;
      s7_fy  <= b_fy;
      s7_dx  <= b_dx;
      s7_dy  <= b_dy;
      s7_n   <= b_n;
      s7_mu  <= b_mu;

      s8_prod <= s7_kmf * s7_smf;
      s8_fy   <= s7_fy;
      s8_dx   <= s7_dx;
      s8_dy   <= s7_dy;
      s8_n    <= s7_n;
      s8_mu   <= s7_mu;

      s9_w  <= {{(WW-33){s8_dx[32]}}, s8_dx} - {2'b00, s8_prod};
      s9_fy <= s8_fy;
      s9_dx <= s8_dx;
      s9_dy <= s8_dy;
      s9_n  <= s8_n;
      s9_mu <= s8_mu;

      s10_aw   <= s9_w[WW-1] ? -s9_w : s9_w;
      s10_wneg <= s9_w[WW-1];
      s10_fy   <= s9_fy;
      s10_dx   <= s9_dx;
      s10_dy   <= s9_dy;
      s10_n    <= s9_n;
      s10_mu   <= s9_mu;

      s11_rwf <= (c_wneg && c_r != '0) ? domain_x - c_r : c_r;
      s11_fy  <= c_fy;
      s11_dx  <= c_dx;
      s11_dy  <= c_dy;
      s11_n   <= c_n;
      s11_mu  <= c_mu;

      // select folded or raw separation
      if (domain_x == '0) begin
        s12_sepx <= s11_dx[31:0];
      end else begin
        s12_sepx <= fx_up ? rwf_ext - {1'b0, domain_x} : rwf_ext;
      end
      s12_sepy <= (domain_y == '0) ? s11_dy[31:0] : s11_fy;
      s12_n    <= s11_n;
      s12_mu   <= s11_mu;

      s13_sqx  <= $signed(s12_sepx) * $signed(s12_sepx);
      s13_sqy  <= $signed(s12_sepy) * $signed(s12_sepy);
      s13_sepx <= s12_sepx;
      s13_sepy <= s12_sepy;
      s13_n    <= s12_n;
      s13_mu   <= s12_mu;

      s14_sq   <= s13_sqx + s13_sqy;
      s14_sepx <= s13_sepx;
      s14_sepy <= s13_sepy;
      s14_n    <= s13_n;
      s14_mu   <= s13_mu;

      s15_len  <= q_rt[SQN][31] ? sbse_pkg::LEN_MAX : q_rt[SQN][LW-1:0];
      s15_sepx <= q_sepx;
      s15_sepy <= q_sepy;
      s15_n    <= q_n;
      s15_mu   <= q_mu;

      s16_diff <= {1'b0, s15_len} - {1'b0, s15_n};
      s16_nz   <= s15_n != '0;
      s16_len  <= s15_len;
      s16_n    <= s15_n;
      s16_mu   <= s15_mu;
      s16_sepx <= s15_sepx;
      s16_sepy <= s15_sepy;

      s17_ad   <= dabs[LW-1:0];
      s17_dneg <= s16_diff[31];
      s17_nz   <= s16_nz;
      s17_len  <= s16_len;
      s17_n    <= s16_n;
      s17_mu   <= s16_mu;
      s17_sepx <= s16_sepx;
      s17_sepy <= s16_sepy;

      // saturate strain
      if (!d_nz) begin
        s18_strain <= (d_len != '0) ? sbse_pkg::STRAIN_MAX : '0;
      end else if (d_dneg) begin
        s18_strain <= big_q ? sbse_pkg::STRAIN_MIN : -d_q[31:0];
      end else begin
        s18_strain <= big_q ? sbse_pkg::STRAIN_MAX : d_q[31:0];
      end
      s18_len  <= d_len;
      s18_mu   <= d_mu;
      s18_sepx <= d_sepx;
      s18_sepy <= d_sepy;

      s19_s2     <= ssq[62:F];
      s19_strain <= s18_strain;
      s19_len    <= s18_len;
      s19_mu     <= s18_mu;
      s19_sepx   <= s18_sepx;
      s19_sepy   <= s18_sepy;

      s20_plo    <= s19_mu * s19_s2[H-1:0];
      s20_s2hi   <= s19_s2[S2W-1:H];
      s20_strain <= s19_strain;
      s20_len    <= s19_len;
      s20_mu     <= s19_mu;
      s20_sepx   <= s19_sepx;
      s20_sepy   <= s19_sepy;

      s21_phi    <= s20_mu * s20_s2hi;
      s21_plo    <= s20_plo;
      s21_strain <= s20_strain;
      s21_len    <= s20_len;
      s21_sepx   <= s20_sepx;
      s21_sepy   <= s20_sepy;

      // output register
      sep_x       <= s21_sepx;
      sep_y       <= s21_sepy;
      bond_length <= s21_len;
      rel_strain  <= s21_strain;
      energy      <= (|eprod[PRW-1:F+1+LW]) ? sbse_pkg::LEN_MAX : eprod[F+LW:F+1];
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) a_vld == s_vld)
    else $error("y fold and shear offset dividers out of step");

  a_zero_strain: assert property (@(posedge clk) disable iff (rst)
    out_valid && rel_strain == '0 |-> energy == '0)
    else $error("nonzero energy at zero strain");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && bond_length == '0 |-> sep_x == '0 && sep_y == '0)
    else $error("zero length with nonzero separation");

endmodule

`default_nettype wire

// ===== rtl/sbse_div.sv =====
`default_nettype none

module sbse_div #(
  parameter int NW = 34,
  parameter int DW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  logic          vld [1:NW];
  logic [NW-1:0] acc [1:NW];
  logic [DW-1:0] par [1:NW];
  logic [DW-1:0] dv  [1:NW];
  logic [SW-1:0] sd  [1:NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          c_vld;
    logic [NW-1:0] c_acc;
    logic [DW-1:0] c_par;
    logic [DW-1:0] c_dv;
    logic [SW-1:0] c_sd;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign c_vld = in_vld;
      assign c_acc = num;
      assign c_par = '0;
      assign c_dv  = den;
      assign c_sd  = side_in;
    end else begin : g_rest
      assign c_vld = vld[i];
      assign c_acc = acc[i];
      assign c_par = par[i];
      assign c_dv  = dv[i];
      assign c_sd  = sd[i];
    end

    assign trial = {c_par, c_acc[NW-1]};
    assign diff  = trial - {1'b0, c_dv};
    assign ge    = trial >= {1'b0, c_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i+1] <= {c_acc[NW-2:0], ge};
        par[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        dv[i+1]  <= c_dv;
        sd[i+1]  <= c_sd;
      end
    end
  end

  assign out_vld  = vld[NW];
  assign quo      = acc[NW];
  assign rem      = par[NW];
  assign side_out = sd[NW];

endmodule

`default_nettype wire
